// File: hw/rtl/srbs_pkg.sv
// ----------------------------------------------------------------------------
// srbs_pkg: shared types and constants of the sync retry backoff supervisor
// Register map, reset values, status codes and the records that pass
// between the configuration block, the step engine and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package srbs_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned RETRY_W = 31;
    localparam int unsigned ADDR_W  = 4;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_RETRY_MIN = 2'd1;
    localparam logic [1:0] REG_RETRY_MAX = 2'd2;

    localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd20000;
    localparam logic [RETRY_W-1:0] RETRY_MIN_RST = 31'd5000;
    localparam logic [RETRY_W-1:0] RETRY_MAX_RST = 31'd300000;

    typedef enum logic [1:0] {
        SYNC_VALID   = 2'd0,
        SYNC_BUSY    = 2'd1,
        SYNC_NOT_SET = 2'd2
    } t_sync_status;

    typedef struct packed {
        logic [TIME_W-1:0]  tmo_limit;
        logic [RETRY_W-1:0] retry_min_ms;
        logic [RETRY_W-1:0] retry_max_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              time_valid;
        logic              link_up;
    } t_item;

    typedef struct packed {
        logic              start_sync;
        logic              timed_out;
        logic              interrupted;
        t_sync_status      sync_status;
        logic [TIME_W-1:0] last_attempt_ms;
        logic [TIME_W-1:0] last_success_ms;
        logic [TIME_W-1:0] retry_due_ms;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/srbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// srbs_cfg_regs: configuration registers
// APB-style register file holding the timeout and the backoff limits.
// ----------------------------------------------------------------------------
`default_nettype none

module srbs_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [srbs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output srbs_pkg::t_cfg                  o_cfg
);
    import srbs_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tmo_limit    <= TIMEOUT_RST;
            r_cfg.retry_min_ms <= RETRY_MIN_RST;
            r_cfg.retry_max_ms <= RETRY_MAX_RST;
        end else if (w_wr) begin
            if (w_idx == REG_TIMEOUT) begin
                r_cfg.tmo_limit <= pwdata;
            end
            if (w_idx == REG_RETRY_MIN) begin
                r_cfg.retry_min_ms <= pwdata[RETRY_W-1:0];
            end
            if (w_idx == REG_RETRY_MAX) begin
                r_cfg.retry_max_ms <= pwdata[RETRY_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_TIMEOUT) begin
            prdata = r_cfg.tmo_limit;
        end else if (w_idx == REG_RETRY_MIN) begin
            prdata = {1'b0, r_cfg.retry_min_ms};
        end else if (w_idx == REG_RETRY_MAX) begin
            prdata = {1'b0, r_cfg.retry_max_ms};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/srbs_engine.sv
// ----------------------------------------------------------------------------
// srbs_engine: supervisor state and single-pass step logic
// Holds the attempt, retry and backoff state and works out one tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module srbs_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire srbs_pkg::t_item i_item,
    input  wire srbs_pkg::t_cfg  i_cfg,
    output srbs_pkg::t_result    o_result
);
    import srbs_pkg::*;

    logic               r_active,      n_active;
    logic [TIME_W-1:0]  r_start,       n_start;
    logic [TIME_W-1:0]  r_last_att,    n_last_att;
    logic [TIME_W-1:0]  r_last_succ,   n_last_succ;
    logic [TIME_W-1:0]  r_retry_at,    n_retry_at;
    logic [RETRY_W-1:0] r_backoff,     n_backoff;
    logic               r_was_valid,   n_was_valid;

    logic               w_start, w_tmo, w_intr;
    logic               w_gained, w_waiting;
    logic [TIME_W-1:0]  w_elapsed, w_since_retry, w_doubled;

    always_comb begin
        n_active    = r_active;
        n_start     = r_start;
        n_last_att  = r_last_att;
        n_last_succ = r_last_succ;
        n_retry_at  = r_retry_at;
        n_backoff   = r_backoff;
        n_was_valid = r_was_valid;
        w_start     = 1'b0;
        w_tmo       = 1'b0;
        w_intr      = 1'b0;

        w_gained      = !r_was_valid || r_active;
        w_elapsed     = i_item.now_ms - r_start;
        w_since_retry = i_item.now_ms - r_retry_at;
        w_waiting     = (r_retry_at != '0) && w_since_retry[TIME_W-1];
        w_doubled     = {r_backoff, 1'b0};

        if (i_item.time_valid) begin
            n_was_valid = 1'b1;
            n_active    = 1'b0;
            n_backoff   = i_cfg.retry_min_ms;
            n_retry_at  = '0;
            if (w_gained || (r_last_succ == '0)) begin
                n_last_succ = i_item.now_ms;
            end
        end else begin
            n_was_valid = 1'b0;
            if (!i_item.link_up) begin
                if (r_active) begin
                    n_active = 1'b0;
                    w_intr   = 1'b1;
                end
            end else if (r_active) begin
                if (w_elapsed >= i_cfg.tmo_limit) begin
                    n_active   = 1'b0;
                    w_tmo      = 1'b1;
                    n_retry_at = i_item.now_ms + {1'b0, r_backoff};
                    // Doubling saturates at the maximum; from half the maximum up the maximum wins,
                    // else below the minimum the minimum wins even when it exceeds the maximum.
                    if (r_backoff >= {1'b0, i_cfg.retry_max_ms[RETRY_W-1:1]}) begin
                        n_backoff = i_cfg.retry_max_ms;
                    end else if (w_doubled < {1'b0, i_cfg.retry_min_ms}) begin
                        n_backoff = i_cfg.retry_min_ms;
                    end else if (w_doubled > {1'b0, i_cfg.retry_max_ms}) begin
                        n_backoff = i_cfg.retry_max_ms;
                    end else begin
                        n_backoff = w_doubled[RETRY_W-1:0];
                    end
                end
            end else if (!w_waiting) begin
                n_active   = 1'b1;
                n_start    = i_item.now_ms;
                n_last_att = i_item.now_ms;
                w_start    = 1'b1;
            end
        end

        o_result.start_sync      = w_start;
        o_result.timed_out       = w_tmo;
        o_result.interrupted     = w_intr;
        o_result.sync_status     = i_item.time_valid ? SYNC_VALID
                                 : (n_active ? SYNC_BUSY : SYNC_NOT_SET);
        o_result.last_attempt_ms = n_last_att;
        o_result.last_success_ms = n_last_succ;
        o_result.retry_due_ms    = n_retry_at;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_start     <= '0;
            r_last_att  <= '0;
            r_last_succ <= '0;
            r_retry_at  <= '0;
            r_backoff   <= RETRY_MIN_RST;
            r_was_valid <= 1'b0;
        end else if (i_adv) begin
            r_active    <= n_active;
            r_start     <= n_start;
            r_last_att  <= n_last_att;
            r_last_succ <= n_last_succ;
            r_retry_at  <= n_retry_at;
            r_backoff   <= n_backoff;
            r_was_valid <= n_was_valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sync_retry_backoff_supervisor.sv
// ----------------------------------------------------------------------------
// sync_retry_backoff_supervisor: time-sync retry timer with exponential backoff
// Each input transfer is one millisecond tick carrying the current time and
// the time-valid and link-up flags; each tick yields exactly one output
// transfer showing the flags of this tick, the sync status and the latest
// attempt, success and retry times. A tick is captured in an input register,
// processed by the step engine and held in an output register,
// so the block sustains one transfer per clock cycle while the output side
// is not stalled; a result passes through the input and output registers
// before it is offered. The input side keeps accepting while a finished
// result waits to be taken, and stalls only when both registers are full.
// Times wrap modulo 2^32 and the pending-retry check uses the signed
// difference to the retry time. The user writes the timeout and the backoff
// limits over the APB-style port only while the block is idle; the block does
// not enforce this. A new minimum takes effect at the next success or clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_retry_backoff_supervisor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] now_ms
    input  wire logic [1:0]  i_s_axis_tuser,   // [0] time_valid, [1] link_up
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] last_attempt_ms, [63:32] last_success_ms, [95:64] retry_due_ms
    output logic [95:0]      o_m_axis_tdata,
    // [0] start_sync, [1] timed_out, [2] interrupted, [4:3] sync_status
    output logic [4:0]       o_m_axis_tuser,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import srbs_pkg::*;

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_adv;

    srbs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held tick is processed when the output register is free or is
    // being emptied in the same cycle.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.now_ms     <= i_s_axis_tdata;
            r_in.time_valid <= i_s_axis_tuser[0];
            r_in.link_up    <= i_s_axis_tuser[1];
        end
    end

    srbs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.retry_due_ms, r_out.last_success_ms,
                              r_out.last_attempt_ms};
    assign o_m_axis_tuser  = {r_out.sync_status, r_out.interrupted,
                              r_out.timed_out, r_out.start_sync};

endmodule

`default_nettype wire

// File: hw/rtl/srbs_checker.sv
// ----------------------------------------------------------------------------
// srbs_checker: port-level checks of the supervisor
// Watches the output stream for consistency between flags and status.
// ----------------------------------------------------------------------------
`default_nettype none

module srbs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [95:0] o_m_axis_tdata,
    input wire logic [4:0]  o_m_axis_tuser
);
    import srbs_pkg::*;

    logic w_start, w_tmo, w_intr;
    logic [1:0] w_status;

    assign w_start  = o_m_axis_tuser[0];
    assign w_tmo    = o_m_axis_tuser[1];
    assign w_intr   = o_m_axis_tuser[2];
    assign w_status = o_m_axis_tuser[4:3];

    // A launched attempt is running at the end of its tick.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_start) |-> (w_status == SYNC_BUSY))
        else $error("start_sync without syncing status");

    // A timeout, which also leaves a retry scheduled or wrapped onto time zero,
    // or an interrupt leaves the attempt ended and the status not set.
    a_end_not_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_tmo || w_intr)) |-> (w_status == SYNC_NOT_SET))
        else $error("ended attempt with wrong status");

    // At most one event per tick.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot0({w_start, w_tmo, w_intr}))
        else $error("more than one event flag set");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled output transfer changed");

endmodule

bind sync_retry_backoff_supervisor srbs_checker u_srbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_sync_retry_backoff_supervisor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_retry_backoff_supervisor: self-checking bench for the sync supervisor
// Millisecond ticks are streamed in, and a scoreboard class predicts the
// status transfer that each accepted tick must produce. Every output transfer
// is compared field by field with the oldest prediction. A short directed run
// covers wrap-around, retries that land on time zero, success at time zero and
// link loss. Random phases follow, each with its own timeout and backoff limits
// and a pattern of idle and stalled cycles.
// ----------------------------------------------------------------------------

module tb_sync_retry_backoff_supervisor;

    import srbs_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: a cycle-free model of the supervisor together with the queue
    // of status transfers that are still due from the block.
    // ------------------------------------------------------------------------
    class supervisor_scoreboard;

        logic [31:0] tmo_limit;
        logic [30:0] retry_min;
        logic [30:0] retry_max;

        logic        attempt_on;
        logic [31:0] attempt_t0;
        logic [31:0] last_attempt;
        logic [31:0] last_success;
        logic [31:0] retry_at;
        logic [31:0] backoff;
        logic        was_valid;

        t_result     status_due[$];
        int          fails;
        int          checked;

        function new();
            tmo_limit    = TIMEOUT_RST;
            retry_min    = RETRY_MIN_RST;
            retry_max    = RETRY_MAX_RST;
            attempt_on   = 1'b0;
            attempt_t0   = '0;
            last_attempt = '0;
            last_success = '0;
            retry_at     = '0;
            backoff      = {1'b0, RETRY_MIN_RST};
            was_valid    = 1'b0;
            fails        = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TIMEOUT:   tmo_limit  = val;
                REG_RETRY_MIN: retry_min  = val[30:0];
                REG_RETRY_MAX: retry_max  = val[30:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        // Advances the model by one tick and queues the status it produces.
        function void note_tick(t_item it);
            logic        gained;
            logic [31:0] elapsed;
            logic [31:0] since_retry;
            logic [31:0] doubled;
            t_result     r;
            r.start_sync  = 1'b0;
            r.timed_out   = 1'b0;
            r.interrupted = 1'b0;
            if (it.time_valid) begin
                gained     = !was_valid || attempt_on;
                was_valid  = 1'b1;
                attempt_on = 1'b0;
                backoff    = {1'b0, retry_min};
                retry_at   = '0;
                if (gained || last_success == 32'd0)
                    last_success = it.now_ms;
            end else begin
                was_valid = 1'b0;
                if (!it.link_up) begin
                    if (attempt_on) begin
                        attempt_on    = 1'b0;
                        r.interrupted = 1'b1;
                    end
                end else if (attempt_on) begin
                    elapsed = it.now_ms - attempt_t0;
                    if (elapsed >= tmo_limit) begin
                        attempt_on  = 1'b0;
                        r.timed_out = 1'b1;
                        retry_at    = it.now_ms + backoff;
                        // Doubling saturates at the maximum; the half-maximum check comes
                        // first, then the minimum check, also when the limits are crossed.
                        if (backoff >= ({1'b0, retry_max} >> 1)) begin
                            backoff = {1'b0, retry_max};
                        end else begin
                            doubled = backoff << 1;
                            if (doubled < {1'b0, retry_min})
                                backoff = {1'b0, retry_min};
                            else if (doubled > {1'b0, retry_max})
                                backoff = {1'b0, retry_max};
                            else
                                backoff = doubled;
                        end
                    end
                end else begin
                    // A retry time of zero means nothing is pending.
                    since_retry = it.now_ms - retry_at;
                    if (retry_at == 32'd0 || !since_retry[31]) begin
                        attempt_on   = 1'b1;
                        attempt_t0   = it.now_ms;
                        last_attempt = it.now_ms;
                        r.start_sync = 1'b1;
                    end
                end
            end
            if (it.time_valid)
                r.sync_status = SYNC_VALID;
            else if (attempt_on)
                r.sync_status = SYNC_BUSY;
            else
                r.sync_status = SYNC_NOT_SET;
            r.last_attempt_ms = last_attempt;
            r.last_success_ms = last_success;
            r.retry_due_ms    = retry_at;
            status_due.push_back(r);
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task cmp(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h expected %0h",
                                 checked, field, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (status_due.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
                want = status_due.pop_front();
                cmp("start_sync",      got.start_sync,      want.start_sync);
                cmp("timed_out",       got.timed_out,       want.timed_out);
                cmp("interrupted",     got.interrupted,     want.interrupted);
                cmp("sync_status",     got.sync_status,     want.sync_status);
                cmp("last_attempt_ms", got.last_attempt_ms, want.last_attempt_ms);
                cmp("last_success_ms", got.last_success_ms, want.last_success_ms);
                cmp("retry_due_ms",    got.retry_due_ms,    want.retry_due_ms);
            end
            checked++;
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata   = '0;   // [31:0] now_ms
    logic [1:0]  i_s_axis_tuser   = '0;   // [0] time_valid, [1] link_up
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready  = 1'b0;
    // [31:0] last_attempt_ms, [63:32] last_success_ms, [95:64] retry_due_ms
    logic [95:0] o_m_axis_tdata;
    // [0] start_sync, [1] timed_out, [2] interrupted, [4:3] sync_status
    logic [4:0]  o_m_axis_tuser;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [3:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    supervisor_scoreboard sb = new();

    // Idle and stall rates in percent, changed from phase to phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Each increment asks the receiver for one long hold-off.
    int unsigned hold_req       = 0;

    // Free-running time used by the well-formed part of the random ticks.
    logic [31:0] clock_ms       = '0;
    int unsigned span           = 10;
    int unsigned valid_pct      = 3;

    sync_retry_backoff_supervisor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor. Both handshakes are sampled at the rising edge, where all of the
    // bench's drives and the block's registers still show their old values, so
    // the order of processes within the time step does not matter. The input
    // transfer is noted before the output is checked, which keeps the check
    // correct whatever the latency of the block.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_item   seen;
        t_result got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen.now_ms     = i_s_axis_tdata;
                seen.time_valid = i_s_axis_tuser[0];
                seen.link_up    = i_s_axis_tuser[1];
                sb.note_tick(seen);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.start_sync      = o_m_axis_tuser[0];
                got.timed_out       = o_m_axis_tuser[1];
                got.interrupted     = o_m_axis_tuser[2];
                got.sync_status     = t_sync_status'(o_m_axis_tuser[4:3]);
                got.last_attempt_ms = o_m_axis_tdata[31:0];
                got.last_success_ms = o_m_axis_tdata[63:32];
                got.retry_due_ms    = o_m_axis_tdata[95:64];
                sb.check_result(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random at the current rate, and on request holds
    // off for a long stretch that it counts itself, so that both registers of
    // the block fill up and the input side is pushed back.
    // ------------------------------------------------------------------------
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one tick, with random idle cycles first, and returns at the edge
    // at which the transfer takes place. The valid stays high for a following
    // tick unless that one starts with idle cycles.
    task automatic send_tick(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= it.now_ms;
        i_s_axis_tuser  <= {it.link_up, it.time_valid};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_at(input logic [31:0] now, input logic valid, input logic link);
        t_item it;
        it.now_ms     = now;
        it.time_valid = valid;
        it.link_up    = link;
        send_tick(it);
    endtask

    // Register write: a setup phase, then an access phase that completes at the
    // edge at which pready is seen high.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops offering ticks and waits until every predicted status has come out,
    // so that the block is idle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly a time that moves forwards in steps of up to the span, with the
    // occasional long jump; the rest is noise with an arbitrary time and flags.
    function automatic t_item next_tick();
        int unsigned pick;
        t_item       it;
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.now_ms     = $urandom;
            it.time_valid = $urandom_range(1);
            it.link_up    = $urandom_range(1);
        end else begin
            if (pick < 11)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(span);
            it.now_ms     = clock_ms;
            it.time_valid = ($urandom_range(99) < valid_pct);
            it.link_up    = ($urandom_range(99) < 88);
        end
        return it;
    endfunction

    task automatic run_phase(input logic [31:0] tmo, input logic [31:0] rmin,
                             input logic [31:0] rmax, input int unsigned step,
                             input int unsigned idle, input int unsigned stall,
                             input bit hold, input int unsigned count);
        drain();
        write_reg(REG_TIMEOUT,   tmo);
        write_reg(REG_RETRY_MIN, rmin);
        write_reg(REG_RETRY_MAX, rmax);
        span           = step;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold)
            hold_req = hold_req + 1;
        repeat (count)
            send_tick(next_tick());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] edge_ms;
        logic [31:0] t;

        // The timeout at edge_ms plus the reset backoff lands exactly on zero.
        edge_ms = 32'hFFFF_EC78;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks under the reset limits, with no idling at all.
        send_at(32'd0, 1'b1, 1'b1);               // success at time zero
        send_at(32'd5, 1'b1, 1'b1);               // rewritten while it holds zero
        send_at(32'd10, 1'b0, 1'b0);              // link down, nothing running
        send_at(edge_ms - 32'd20000, 1'b0, 1'b1); // attempt starts
        send_at(edge_ms - 32'd1, 1'b0, 1'b1);     // one short of the timeout
        send_at(edge_ms, 1'b0, 1'b1);             // times out, retry wraps to zero
        send_at(edge_ms + 32'd1, 1'b0, 1'b1);     // retry at zero is not pending
        send_at(edge_ms + 32'd2, 1'b0, 1'b0);     // link loss aborts the attempt
        send_at(edge_ms + 32'd3, 1'b0, 1'b1);
        t = edge_ms + 32'd3 + 32'd20000;          // elapsed time across the wrap
        send_at(t, 1'b0, 1'b1);
        send_at(t + 32'd5000, 1'b0, 1'b1);        // retry still pending
        send_at(t + 32'd10000, 1'b0, 1'b1);       // retry due exactly now
        send_at(t + 32'd10001, 1'b1, 1'b0);       // valid time ends the attempt
        send_at(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_at(32'd0, 1'b0, 1'b1);
        send_at(32'h8000_0000, 1'b0, 1'b1);       // half the time range elapsed
        send_at(32'h8000_0001, 1'b0, 1'b0);
        send_at(32'h8000_0002, 1'b1, 1'b1);
        send_at(32'h7FFF_FFFF, 1'b1, 1'b0);       // still valid, not regained

        // Random phases; the limits include the extremes, a zero timeout and a
        // minimum above the maximum, and the retry registers see bit 31 set.
        run_phase(32'd40, 32'd3, 32'd200, 15, 0, 0, 1'b0, 250);
        run_phase(32'd1, 32'd1, 32'd1, 3, 74, 0, 1'b0, 250);
        run_phase(32'd100, 32'd50, 32'd20, 40, 0, 74, 1'b0, 250);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000, 37, 37, 1'b0, 250);
        run_phase(32'd10, 32'h3000_0000, 32'h7FFF_FFFF, 8, 0, 0, 1'b1, 250);
        run_phase($urandom_range(1, 60), {1'b1, 31'($urandom_range(1, 30))},
                  {1'b1, 31'($urandom_range(1, 400))}, 20, 37, 37, 1'b0, 250);
        run_phase(32'd0, 32'd5, 32'd9, 4, 74, 0, 1'b0, 250);
        run_phase($urandom_range(1, 60), $urandom_range(1, 30),
                  $urandom_range(1, 400), 20, 0, 74, 1'b1, 250);

        // Let everything come out, then watch a while longer for strays.
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0)
            $display("** sync_retry_backoff_supervisor: PASSED **");
        else
            $display("** sync_retry_backoff_supervisor: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("** sync_retry_backoff_supervisor: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/srbs_pkg.sv
hw/rtl/srbs_cfg_regs.sv
hw/rtl/srbs_engine.sv
hw/rtl/sync_retry_backoff_supervisor.sv
hw/rtl/srbs_checker.sv
tb/tb_sync_retry_backoff_supervisor.sv
